// ===== rtl/crossfaded_waveshaping_distortion_defines.svh =====
// Assertion macros for the crossfaded waveshaping distortion block.
`ifndef CROSSFADED_WAVESHAPING_DISTORTION_DEFINES_SVH
`define CROSSFADED_WAVESHAPING_DISTORTION_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CWD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CWD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/cwd_pkg.sv =====
// Shared types, register codes and curve table generation for the distortion block.
package cwd_pkg;

  typedef struct packed {
    logic [15:0] gain;
    logic [15:0] crunch;
    logic [15:0] volume;
    logic [1:0]  stage;
  } cwd_cfg_t;

  localparam logic [1:0] REG_GAIN   = 2'd0;
  localparam logic [1:0] REG_CRUNCH = 2'd1;
  localparam logic [1:0] REG_VOLUME = 2'd2;
  localparam logic [1:0] REG_STAGE  = 2'd3;

  localparam logic [1:0] STAGE_SOFT = 2'd1;
  localparam logic [1:0] STAGE_HARD = 2'd2;

  localparam int CURVE_ATAN = 0;
  localparam int CURVE_TANH = 1;
  localparam int CURVE_ERF  = 2;

  localparam logic [63:0] Q30               = 64'd1 << 30;
  localparam logic [63:0] K_HALF_PI         = 64'd1686629713;
  localparam logic [63:0] K_TWO_OVER_PI     = 64'd683565276;
  localparam logic [63:0] K_SQRT2_APPROX    = 64'd1518270939;
  localparam logic [63:0] K_TWO_OVER_SQRTPI = 64'd1211587906;

  // Q30 product, truncated.
  function automatic logic [63:0] mulq(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] pr;
    pr = {64'd0, a} * {64'd0, b};
    return pr[93:30];
  endfunction

  // Restoring shift-subtract quotient, used only while building tables.
  function automatic logic [63:0] udiv(input logic [63:0] n, input logic [63:0] d);
    logic [64:0] rem;
    logic [63:0] q;
    rem = '0;
    q = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], n[i]};
      if (rem >= {1'b0, d}) begin
        rem = rem - {1'b0, d};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] bt;
    v = v_in;
    r = '0;
    bt = 64'd1 << 62;
    while (bt > v) bt = bt >> 2;
    while (bt != 64'd0) begin
      if (v >= r + bt) begin
        v = v - (r + bt);
        r = (r >> 1) + bt;
      end else begin
        r = r >> 1;
      end
      bt = bt >> 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] exp_neg(input logic [63:0] y);
    logic [63:0] z;
    logic [63:0] term;
    logic signed [63:0] sum;
    z = y >> 5;
    term = Q30;
    sum = $signed(Q30);
    for (int n = 1; n <= 20; n++) begin
      term = udiv(mulq(term, z), 64'(n));
      if ((n % 2) == 1) sum = sum - $signed(term);
      else sum = sum + $signed(term);
    end
    for (int k = 0; k < 5; k++) sum = $signed(mulq(sum, sum));
    return sum;
  endfunction

  function automatic logic [63:0] tanh_q30(input logic [63:0] t);
    logic [63:0] e;
    e = exp_neg(t << 1);
    return udiv((Q30 - e) << 30, Q30 + e);
  endfunction

  function automatic logic [63:0] atan_q30(input logic [63:0] t);
    logic [63:0] u;
    logic [63:0] v;
    logic [63:0] p;
    logic [63:0] v2;
    logic [63:0] s;
    logic [63:0] theta;
    logic inv;
    logic signed [63:0] sum;
    u = mulq(K_HALF_PI, t);
    v = u;
    inv = 1'b0;
    sum = '0;
    if (u > Q30) begin
      v = udiv(64'd1 << 60, u);
      inv = 1'b1;
    end
    for (int k = 0; k < 2; k++) begin
      s = isqrt64((64'd1 << 60) + v * v);
      v = udiv(v << 30, Q30 + s);
    end
    v2 = mulq(v, v);
    p = v;
    for (int n = 0; n < 15; n++) begin
      if ((n % 2) == 1) sum = sum - $signed(udiv(p, 64'(2 * n + 1)));
      else sum = sum + $signed(udiv(p, 64'(2 * n + 1)));
      p = mulq(p, v2);
    end
    theta = sum << 2;
    if (inv) theta = K_HALF_PI - theta;
    return mulq(K_TWO_OVER_PI, theta);
  endfunction

  function automatic logic [63:0] erf_q30(input logic [63:0] t);
    logic [63:0] z;
    logic [63:0] z2;
    logic [63:0] w;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] r;
    z = mulq(K_SQRT2_APPROX, t);
    if (z >= (Q30 << 2)) return Q30;
    z2 = mulq(z, z);
    w = z2 << 1;
    term = z;
    sum = z;
    for (int n = 0; n < 200; n++) begin
      term = udiv(mulq(term, w), 64'(2 * n + 3));
      if (term == 64'd0) break;
      sum = sum + term;
    end
    r = mulq(mulq(sum, exp_neg(z2)), K_TWO_OVER_SQRTPI);
    return (r > Q30) ? Q30 : r;
  endfunction

  // One table entry, rounded to the sample format and capped at one.
  function automatic logic [63:0] rom_entry(input int curve, input int i, input int depth,
                                            input int frac);
    logic [63:0] t;
    logic [63:0] f;
    logic [63:0] v;
    logic [63:0] one;
    t = udiv(64'd5 * Q30 * 64'(i), 64'(depth - 1));
    case (curve)
      CURVE_ATAN: f = atan_q30(t);
      CURVE_TANH: f = tanh_q30(t);
      default:    f = erf_q30(t);
    endcase
    if (frac < 30) v = (f + (64'd1 << (29 - frac))) >> (30 - frac);
    else v = f << (frac - 30);
    one = 64'd1 << frac;
    return (v > one) ? one : v;
  endfunction

endpackage

// ===== rtl/crossfaded_waveshaping_distortion.sv =====
// Top level of the crossfaded waveshaping distortion block.
//
//   channel   direction  transfer on                 payload
//   s_*       in         s_tvalid & s_tready         s_tdata: sample_in
//   m_*       out        m_tvalid & m_tready         m_tdata: sample_out
//   cfg_*     in         cfg_we                      cfg_index, cfg_data
//
// One sample is taken per clock while s_tready is high; a result shows on m_tvalid
// once it has passed the ten register stages, the first loaded by the input transfer:
// pre-gain multiply, index and cubic multiplies, table read, crossfade and volume
// multiplies, saturation. Reset clears all stage valid bits and loads the register
// defaults. A held output stalls only full stages; bubbles are squeezed out, so
// s_tready drops only while m_tvalid waits on m_tready.
`include "crossfaded_waveshaping_distortion_defines.svh"

module crossfaded_waveshaping_distortion import cwd_pkg::*; #(
  parameter int TABLE_DEPTH = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]       s_tdata,  // sample_in
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]       m_tdata,  // sample_out
  input  logic                                   cfg_we,
  input  logic [1:0]                             cfg_index,
  input  logic [15:0]                            cfg_data
);

  localparam int W  = SAMPLE_BITS;
  localparam int TW = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int DB = $clog2(TABLE_DEPTH);

  cwd_cfg_t cfg;

  logic                 f_valid, b_ready;
  logic [DB-1:0]        f_idx;
  logic [W-1:0]         f_cub, f_hard;
  logic signed [W+2:0]  f_x;
  logic                 f_neg;
  logic [W-1:0]         atan_q, tanh_q, erf_q;
  logic [W-1:0]         out_sample;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain <= '0;
      cfg.crunch <= '0;
      cfg.volume <= '0;
      cfg.stage <= STAGE_SOFT;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GAIN:   cfg.gain <= cfg_data;
        REG_CRUNCH: cfg.crunch <= cfg_data;
        REG_VOLUME: cfg.volume <= cfg_data;
        REG_STAGE:  cfg.stage <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  cwd_front #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .gain     (cfg.gain),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sample   ($signed(s_tdata[W-1:0])),
    .out_valid(f_valid),
    .out_ready(b_ready),
    .idx      (f_idx),
    .cub_mag  (f_cub),
    .hard_mag (f_hard),
    .x_out    (f_x),
    .neg_out  (f_neg)
  );

  cwd_rom #(.CURVE(CURVE_ATAN), .DEPTH(TABLE_DEPTH), .BITS(W)) u_rom_atan (
    .clk(clk), .en(b_ready), .addr(f_idx), .data(atan_q)
  );

  cwd_rom #(.CURVE(CURVE_TANH), .DEPTH(TABLE_DEPTH), .BITS(W)) u_rom_tanh (
    .clk(clk), .en(b_ready), .addr(f_idx), .data(tanh_q)
  );

  cwd_rom #(.CURVE(CURVE_ERF), .DEPTH(TABLE_DEPTH), .BITS(W)) u_rom_erf (
    .clk(clk), .en(b_ready), .addr(f_idx), .data(erf_q)
  );

  cwd_back #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (f_valid),
    .in_ready (b_ready),
    .atan_mag (atan_q),
    .tanh_mag (tanh_q),
    .erf_mag  (erf_q),
    .cub_mag  (f_cub),
    .hard_mag (f_hard),
    .x_in     (f_x),
    .neg_in   (f_neg),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .sample   (out_sample)
  );

  assign m_tdata = TW'(out_sample);

  `CWD_ASSERT_NOW(a_stall_source, !s_tready, m_tvalid && !m_tready, "input blocked without output stall")
  `CWD_ASSERT_NEXT(a_stage_write, cfg_we && cfg_index == REG_STAGE, cfg.stage == $past(cfg_data[1:0]), "stage register not written")
  `CWD_ASSERT_NOW(a_reset_empty, $past(rst), !m_tvalid, "output valid right after reset")

endmodule

// ===== rtl/cwd_rom.sv =====
// Curve lookup table with registered read data.
module cwd_rom import cwd_pkg::*; #(
  parameter int CURVE = 0,
  parameter int DEPTH = 1024,
  parameter int BITS  = 16
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic [$clog2(DEPTH)-1:0] addr,
  output logic [BITS-1:0]          data
);

  logic [BITS-1:0] tbl [DEPTH];

  for (genvar gi = 0; gi < DEPTH; gi++) begin : g_ent
    localparam logic [BITS-1:0] VAL = BITS'(rom_entry(CURVE, gi, DEPTH, BITS - 1));
    assign tbl[gi] = VAL;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data <= tbl[addr];
    end
  end

endmodule

// ===== rtl/cwd_front.sv =====
// Front pipeline: pre-gain, table index, cubic and hard clip magnitudes.
module cwd_front import cwd_pkg::*; #(
  parameter int TABLE_DEPTH = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [15:0]                     gain,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [SAMPLE_BITS-1:0]   sample,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [$clog2(TABLE_DEPTH)-1:0]  idx,
  output logic [SAMPLE_BITS-1:0]          cub_mag,
  output logic [SAMPLE_BITS-1:0]          hard_mag,
  output logic signed [SAMPLE_BITS+2:0]   x_out,
  output logic                            neg_out
);

  localparam int W    = SAMPLE_BITS;
  localparam int FRAC = W - 1;
  localparam int DB   = $clog2(TABLE_DEPTH);
  localparam int PW   = W + 20;
  localparam int XW   = W + 3;
  localparam int NW   = XW + DB + 1;
  localparam int DW   = W + 1;
  localparam int SQW  = 2 * DW;
  localparam int MIW  = DB + 3;
  localparam int S5   = DB + 6;
  localparam int K5W  = DB + 4;
  localparam int S3   = W + 3;
  localparam int K3W  = W + 2;
  localparam int MCW  = W + 1;
  localparam longint ONE_L = longint'(1) << FRAC;
  localparam logic [XW-1:0]  ONE_X  = XW'(ONE_L);
  localparam logic [XW-1:0]  T1     = XW'((ONE_L + 1) / 3);
  localparam logic [XW-1:0]  T2     = XW'((2 * ONE_L + 1) / 3);
  localparam logic [XW:0]    TWO_ONE = (XW + 1)'(2 * ONE_L);
  localparam logic [DB-1:0]  DM1    = DB'(TABLE_DEPTH - 1);
  localparam logic [NW-1:0]  HALF5  = NW'((5 * ONE_L) / 2);
  localparam logic [SQW-1:0] HALF3  = SQW'((3 * ONE_L) / 2);
  localparam logic [K5W-1:0] K5     = K5W'(((longint'(1) << S5) + 4) / 5);
  localparam logic [K3W-1:0] K3     = K3W'(((longint'(1) << S3) + 2) / 3);

  logic v1, v2, v3, v4, v5;
  logic en1, en2, en3, en4, en5;

  logic signed [PW-1:0] p1;
  logic signed [XW-1:0] x2, x3, x4;
  logic [XW-1:0]        a2;
  logic                 n2, n3, n4;
  logic [NW-1:0]        nidx3;
  logic [SQW-1:0]       dsq3;
  logic                 mid3, hi3, mid4, hi4;
  logic [W-1:0]         hard3, hard4, two_a3, two_a4;
  logic [MIW+K5W-1:0]   qi4;
  logic [MCW+K3W-1:0]   qc4;

  logic signed [PW-1:0] p_round;
  logic signed [XW-1:0] x_w;
  logic [XW:0]          d_w;
  logic [DW-1:0]        d_sel;
  logic [XW+1:0]        a5_w;
  logic [MIW-1:0]       mi_w;
  logic [MCW-1:0]       mc_w;
  logic [DB:0]          q5_w;
  logic [W-1:0]         qc_w;

  always_comb begin
    en5 = !v5 || out_ready;
    en4 = !v4 || en5;
    en3 = !v3 || en4;
    en2 = !v2 || en3;
    en1 = !v1 || en2;
  end

  assign in_ready = en1;
  assign out_valid = v5;

  always_comb begin
    p_round = p1 + PW'(32768);
    x_w = XW'(p_round >>> 16);
    d_w = TWO_ONE - ({1'b0, a2} + {a2, 1'b0});
    d_sel = (a2 >= T1 && a2 < T2) ? d_w[DW-1:0] : '0;
    a5_w = {2'b00, a2} + {a2, 2'b00};
    mi_w = MIW'((nidx3 + HALF5) >> FRAC);
    mc_w = MCW'((dsq3 + HALF3) >> FRAC);
    q5_w = (DB + 1)'(qi4 >> S5);
    qc_w = W'(qc4 >> S3);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      p1 <= PW'(sample) * PW'($signed({1'b0, {gain, 2'b00} + {3'b000, gain}}));
    end
    if (en2) begin
      x2 <= x_w;
      n2 <= x_w[XW-1];
      a2 <= x_w[XW-1] ? XW'(-x_w) : XW'(x_w);
    end
    if (en3) begin
      x3 <= x2;
      n3 <= n2;
      nidx3 <= NW'(a2) * NW'(DM1);
      dsq3 <= SQW'(d_sel) * SQW'(d_sel);
      mid3 <= (a2 >= T1) && (a2 < T2);
      hi3 <= a2 >= T2;
      hard3 <= (a5_w >= (XW + 2)'(ONE_X)) ? W'(ONE_L) : W'(a5_w);
      two_a3 <= W'({a2, 1'b0});
    end
    if (en4) begin
      x4 <= x3;
      n4 <= n3;
      mid4 <= mid3;
      hi4 <= hi3;
      hard4 <= hard3;
      two_a4 <= two_a3;
      qi4 <= (MIW + K5W)'(mi_w) * (MIW + K5W)'(K5);
      qc4 <= (MCW + K3W)'(mc_w) * (MCW + K3W)'(K3);
    end
    if (en5) begin
      x_out <= x4;
      neg_out <= n4;
      hard_mag <= hard4;
      idx <= (q5_w > (DB + 1)'(DM1)) ? DM1 : DB'(q5_w);
      if (hi4) cub_mag <= W'(ONE_L);
      else if (mid4) cub_mag <= W'(ONE_L) - qc_w;
      else cub_mag <= two_a4;
    end
  end

endmodule

// ===== rtl/cwd_back.sv =====
// Back pipeline: curve selection, crossfade, volume and saturation.
module cwd_back import cwd_pkg::*; #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  cwd_cfg_t                      cfg,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [SAMPLE_BITS-1:0]        atan_mag,
  input  logic [SAMPLE_BITS-1:0]        tanh_mag,
  input  logic [SAMPLE_BITS-1:0]        erf_mag,
  input  logic [SAMPLE_BITS-1:0]        cub_mag,
  input  logic [SAMPLE_BITS-1:0]        hard_mag,
  input  logic signed [SAMPLE_BITS+2:0] x_in,
  input  logic                          neg_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [SAMPLE_BITS-1:0]        sample
);

  localparam int W    = SAMPLE_BITS;
  localparam int FRAC = W - 1;
  localparam int YW   = W + 3;
  localparam int DFW  = YW + 1;
  localparam int MPW  = DFW + 18;
  localparam int YPW  = DFW + 17;
  localparam longint ONE_L = longint'(1) << FRAC;
  localparam logic signed [YPW-1:0] SMAX = YPW'(ONE_L - 1);
  localparam logic signed [YPW-1:0] SMIN = YPW'(-ONE_L);

  logic v6, v7, v8, v9, vo;
  logic en6, en7, en8, en9, eno;

  // Stage 6 payload; the table words are registered inside the lookup tables.
  logic [W-1:0]         cub6, hard6;
  logic signed [YW-1:0] x6;
  logic                 n6;
  logic signed [YW-1:0] a7, a8;
  logic signed [DFW-1:0] diff7;
  logic signed [MPW-1:0] mp8;
  logic signed [YPW-1:0] yp9;

  logic                  low;
  logic [16:0]           ratio;
  logic signed [YW-1:0]  s_v, t_v, e_v, c_v, h_v, a_v, b_v;
  logic signed [MPW-1:0] mp_w, mr_w;
  logic signed [DFW-1:0] y_w;
  logic signed [YPW-1:0] yp_w, yr_w;

  function automatic logic signed [YW-1:0] apply_sign(input logic [W-1:0] m, input logic n);
    logic signed [YW-1:0] sv;
    sv = YW'($signed({1'b0, m}));
    return n ? -sv : sv;
  endfunction

  always_comb begin
    eno = !vo || out_ready;
    en9 = !v9 || eno;
    en8 = !v8 || en9;
    en7 = !v7 || en8;
    en6 = !v6 || en7;
  end

  assign in_ready = en6;
  assign out_valid = vo;

  always_comb begin
    low = cfg.crunch <= 16'd32768;
    ratio = low ? {cfg.crunch, 1'b0} : ({cfg.crunch, 1'b0} - 17'd65536);
    s_v = apply_sign(atan_mag, n6);
    t_v = apply_sign(tanh_mag, n6);
    e_v = apply_sign(erf_mag, n6);
    c_v = apply_sign(cub6, n6);
    h_v = apply_sign(hard6, n6);
    case (cfg.stage)
      STAGE_SOFT: begin
        a_v = low ? s_v : t_v;
        b_v = low ? t_v : e_v;
      end
      STAGE_HARD: begin
        a_v = low ? e_v : c_v;
        b_v = low ? c_v : h_v;
      end
      default: begin
        a_v = x6;
        b_v = x6;
      end
    endcase
    mp_w = MPW'(diff7) * MPW'($signed({1'b0, ratio}));
    mr_w = mp8 + MPW'(32768);
    y_w = DFW'(a8) + DFW'(mr_w >>> 16);
    yp_w = YPW'(y_w) * YPW'($signed({1'b0, cfg.volume}));
    yr_w = (yp9 + YPW'(32768)) >>> 16;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
      v7 <= 1'b0;
      v8 <= 1'b0;
      v9 <= 1'b0;
      vo <= 1'b0;
    end else begin
      if (en6) v6 <= in_valid;
      if (en7) v7 <= v6;
      if (en8) v8 <= v7;
      if (en9) v9 <= v8;
      if (eno) vo <= v9;
    end
  end

  always_ff @(posedge clk) begin
    if (en6) begin
      cub6 <= cub_mag;
      hard6 <= hard_mag;
      x6 <= x_in;
      n6 <= neg_in;
    end
    if (en7) begin
      a7 <= a_v;
      diff7 <= DFW'(b_v) - DFW'(a_v);
    end
    if (en8) begin
      a8 <= a7;
      mp8 <= mp_w;
    end
    if (en9) begin
      yp9 <= yp_w;
    end
    if (eno) begin
      if (yr_w > SMAX) sample <= W'(SMAX);
      else if (yr_w < SMIN) sample <= W'(SMIN);
      else sample <= W'(yr_w);
    end
  end

endmodule

// ===== dv/tb_crossfaded_waveshaping_distortion.sv =====
// Testbench for the crossfaded waveshaping distortion block: directed and random samples.
`timescale 1ns / 1ps

module tb_crossfaded_waveshaping_distortion;
  import cwd_pkg::*;

  localparam int DEPTH = 1024;
  localparam longint UNIT = 32768;
  localparam logic [1:0] STAGE_BYPASS = 2'd0;
  localparam logic [1:0] STAGE_SPARE = 2'd3;
  localparam int CYCLE_LIMIT = 600000;

  typedef struct {
    int gain;
    int crunch;
    int volume;
    int stage;
    int smp;
    bit typed;
    int want;
  } dir_row_t;

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [15:0] s_tdata;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [15:0] cfg_data;

  crossfaded_waveshaping_distortion u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  longint atan_curve[DEPTH];
  longint tanh_curve[DEPTH];
  longint erf_curve[DEPTH];
  logic [15:0] gain_r, crunch_r, volume_r;
  logic [1:0] stage_r;
  logic [15:0] pending_out[$];
  int send_idle, recv_idle;
  int errors = 0;
  int cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] fx_mul(logic [63:0] a, logic [63:0] b);
    logic [127:0] pr;
    pr = {64'd0, a} * {64'd0, b};
    return pr[93:30];
  endfunction

  function automatic logic [63:0] fx_sqrt(logic [63:0] v_in);
    logic [63:0] v, r, bt;
    v = v_in;
    r = 0;
    bt = 64'd1 << 62;
    while (bt > v) bt = bt >> 2;
    while (bt != 0) begin
      if (v >= r + bt) begin
        v = v - (r + bt);
        r = (r >> 1) + bt;
      end else begin
        r = r >> 1;
      end
      bt = bt >> 2;
    end
    return r;
  endfunction

  // Taylor series on y/32, then squared five times.
  function automatic logic [63:0] decay(logic [63:0] y);
    logic [63:0] z, term;
    longint acc;
    z = y >> 5;
    term = Q30;
    acc = longint'(Q30);
    for (int n = 1; n <= 20; n++) begin
      term = fx_mul(term, z) / n;
      if (n % 2 == 1) acc -= longint'(term);
      else acc += longint'(term);
    end
    for (int k = 0; k < 5; k++) acc = longint'(fx_mul(acc, acc));
    return acc;
  endfunction

  function automatic logic [63:0] tanh_fx(logic [63:0] t);
    logic [63:0] e;
    e = decay(t << 1);
    return ((Q30 - e) << 30) / (Q30 + e);
  endfunction

  function automatic logic [63:0] atan_fx(logic [63:0] t);
    logic [63:0] u, v, p, v2, sq, theta;
    logic inv;
    longint acc;
    u = fx_mul(K_HALF_PI, t);
    v = u;
    inv = 1'b0;
    acc = 0;
    if (u > Q30) begin
      v = (64'd1 << 60) / u;
      inv = 1'b1;
    end
    // Two half-angle reductions before the series.
    for (int k = 0; k < 2; k++) begin
      sq = fx_sqrt((64'd1 << 60) + v * v);
      v = (v << 30) / (Q30 + sq);
    end
    v2 = fx_mul(v, v);
    p = v;
    for (int n = 0; n < 15; n++) begin
      if (n % 2 == 1) acc -= longint'(p / (2 * n + 1));
      else acc += longint'(p / (2 * n + 1));
      p = fx_mul(p, v2);
    end
    theta = 64'(acc) << 2;
    if (inv) theta = K_HALF_PI - theta;
    return fx_mul(K_TWO_OVER_PI, theta);
  endfunction

  function automatic logic [63:0] erf_fx(logic [63:0] t);
    logic [63:0] z, z2, w, term, acc, r;
    z = fx_mul(K_SQRT2_APPROX, t);
    if (z >= (Q30 << 2)) return Q30;
    z2 = fx_mul(z, z);
    w = z2 << 1;
    term = z;
    acc = z;
    for (int n = 0; n < 200; n++) begin
      term = fx_mul(term, w) / (2 * n + 3);
      if (term == 0) break;
      acc = acc + term;
    end
    r = fx_mul(fx_mul(acc, decay(z2)), K_TWO_OVER_SQRTPI);
    return (r > Q30) ? Q30 : r;
  endfunction

  function automatic longint to_q15(logic [63:0] f);
    logic [63:0] v;
    v = (f + (64'd1 << 14)) >> 15;
    return (v > UNIT) ? UNIT : longint'(v);
  endfunction

  function automatic void build_curves();
    logic [63:0] t;
    for (int i = 0; i < DEPTH; i++) begin
      t = (64'd5 * Q30 * 64'(i)) / (DEPTH - 1);
      atan_curve[i] = to_q15(atan_fx(t));
      tanh_curve[i] = to_q15(tanh_fx(t));
      erf_curve[i] = to_q15(erf_fx(t));
    end
  endfunction

  function automatic longint curve_at(int which, longint x);
    longint a, idx, v;
    a = (x < 0) ? -x : x;
    idx = (a * (DEPTH - 1) + 5 * UNIT / 2) / (5 * UNIT);
    if (idx > DEPTH - 1) idx = DEPTH - 1;
    case (which)
      CURVE_ATAN: v = atan_curve[idx];
      CURVE_TANH: v = tanh_curve[idx];
      default:    v = erf_curve[idx];
    endcase
    return (x < 0) ? -v : v;
  endfunction

  function automatic longint cubic(longint x);
    longint a, y, d;
    a = (x < 0) ? -x : x;
    if (a >= (2 * UNIT + 1) / 3) y = UNIT;
    else if (a >= (UNIT + 1) / 3) begin
      d = 2 * UNIT - 3 * a;
      y = UNIT - (d * d + 3 * UNIT / 2) / (3 * UNIT);
    end else y = 2 * a;
    return (x < 0) ? -y : y;
  endfunction

  function automatic longint hard(longint x);
    longint y;
    y = 5 * x;
    if (y > UNIT) y = UNIT;
    if (y < -UNIT) y = -UNIT;
    return y;
  endfunction

  function automatic longint fade(longint a, longint b, longint r);
    return a + (((b - a) * r + 32768) >>> 16);
  endfunction

  function automatic logic [15:0] shape_sample(logic [15:0] smp);
    longint s, x, y, r;
    bit low;
    s = longint'($signed(smp));
    low = crunch_r <= 16'd32768;
    x = (s * (5 * longint'(gain_r)) + 32768) >>> 16;
    r = low ? 2 * longint'(crunch_r) : 2 * longint'(crunch_r) - 65536;
    if (stage_r == STAGE_SOFT) begin
      if (low) y = fade(curve_at(CURVE_ATAN, x), curve_at(CURVE_TANH, x), r);
      else y = fade(curve_at(CURVE_TANH, x), curve_at(CURVE_ERF, x), r);
    end else if (stage_r == STAGE_HARD) begin
      if (low) y = fade(curve_at(CURVE_ERF, x), cubic(x), r);
      else y = fade(cubic(x), hard(x), r);
    end else begin
      y = x;
    end
    y = (y * longint'(volume_r) + 32768) >>> 16;
    if (y > UNIT - 1) y = UNIT - 1;
    if (y < -UNIT) y = -UNIT;
    return y[15:0];
  endfunction

  // Registers change only once the pipeline has emptied.
  task automatic set_knobs(int g, int c, int v, int st);
    wait (pending_out.size() == 0);
    repeat (12) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_GAIN;
    cfg_data <= 16'(g);
    @(posedge clk);
    cfg_index <= REG_CRUNCH;
    cfg_data <= 16'(c);
    @(posedge clk);
    cfg_index <= REG_VOLUME;
    cfg_data <= 16'(v);
    @(posedge clk);
    cfg_index <= REG_STAGE;
    cfg_data <= 16'(st);
    @(posedge clk);
    cfg_we <= 1'b0;
    gain_r = 16'(g);
    crunch_r = 16'(c);
    volume_r = 16'(v);
    stage_r = 2'(st);
  endtask

  task automatic send_sample(logic [15:0] smp, bit typed, logic [15:0] want);
    if ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= smp;
    do @(posedge clk); while (!s_tready);
    pending_out.push_back(typed ? want : shape_sample(smp));
  endtask

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(9))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'($urandom_range(15)) - 16'd8;
      3, 4: return 16'($signed(16'($urandom_range(8191))) - 16'sd4096);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic int pick_knob();
    case ($urandom_range(7))
      0: return 0;
      1: return 65535;
      2: return 32768 + $urandom_range(1) - $urandom_range(1);
      3: return $urandom_range(16383);
      default: return $urandom_range(65535);
    endcase
  endfunction

  task automatic random_block(int count);
    set_knobs(pick_knob(), pick_knob(), pick_knob(), $urandom_range(3));
    for (int i = 0; i < count; i++) send_sample(pick_sample(), 1'b0, 16'd0);
    s_tvalid <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (pending_out.size() == 0) begin
          $error("sample_out transfer with nothing expected: actual %0d", $signed(m_tdata));
          errors++;
        end else begin
          if (m_tdata !== pending_out[0]) begin
            $error("sample_out mismatch: expected %0d actual %0d",
                   $signed(pending_out[0]), $signed(m_tdata));
            errors++;
          end
          void'(pending_out.pop_front());
        end
      end
      m_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_crossfaded_waveshaping_distortion NOT OK");
      $finish;
    end
  end

  dir_row_t dir_rows[] = '{
    '{0, 0, 0, 1, 32767, 1, 0},
    '{0, 0, 0, 1, -32768, 1, 0},
    '{65535, 0, 65535, 0, 32767, 1, 32767},
    '{65535, 0, 65535, 0, -32768, 1, -32768},
    '{65535, 0, 65535, 0, 0, 1, 0},
    '{13107, 0, 65535, 3, 1000, 0, 0},
    '{65535, 0, 65535, 1, 32767, 0, 0},
    '{65535, 0, 65535, 1, -32768, 0, 0},
    '{65535, 32768, 65535, 1, 12000, 0, 0},
    '{65535, 32769, 65535, 1, -9000, 0, 0},
    '{65535, 65535, 65535, 1, 32767, 0, 0},
    '{65535, 0, 65535, 2, 32767, 0, 0},
    '{65535, 0, 65535, 2, -20000, 0, 0},
    '{13107, 32769, 65535, 2, 10922, 0, 0},
    '{13107, 32769, 65535, 2, 10923, 0, 0},
    '{13107, 32769, 65535, 2, 21844, 0, 0},
    '{13107, 32769, 65535, 2, 21845, 0, 0},
    '{13107, 32769, 65535, 2, -21845, 0, 0},
    '{13107, 32769, 65535, 2, -5000, 0, 0},
    '{13107, 65535, 65535, 2, 3000, 0, 0},
    '{13107, 65535, 65535, 2, -32768, 0, 0},
    '{65535, 65535, 65535, 2, 1, 0, 0},
    '{0, 32768, 32768, 1, 12345, 0, 0},
    '{40000, 20000, 30000, 1, -1, 0, 0}
  };

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    send_idle = 17;
    recv_idle = 70;
    gain_r = 0;
    crunch_r = 0;
    volume_r = 0;
    stage_r = STAGE_SOFT;
    build_curves();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      if (16'(dir_rows[i].gain) != gain_r || 16'(dir_rows[i].crunch) != crunch_r ||
          16'(dir_rows[i].volume) != volume_r || 2'(dir_rows[i].stage) != stage_r) begin
        s_tvalid <= 1'b0;
        set_knobs(dir_rows[i].gain, dir_rows[i].crunch, dir_rows[i].volume,
                  dir_rows[i].stage);
      end
      send_sample(16'(dir_rows[i].smp), dir_rows[i].typed, 16'(dir_rows[i].want));
    end
    s_tvalid <= 1'b0;

    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 17 : (ph == 1) ? 70 : 0;
      recv_idle = (ph == 0) ? 70 : (ph == 1) ? 17 : 0;
      for (int b = 0; b < 7; b++) random_block(60);
    end
    // The random blocks above vary each register; end on extremes.
    set_knobs(65535, 65535, 65535, STAGE_BYPASS);
    for (int i = 0; i < 20; i++) send_sample(pick_sample(), 1'b0, 16'd0);
    s_tvalid <= 1'b0;
    set_knobs(0, 0, 0, STAGE_SPARE);
    for (int i = 0; i < 20; i++) send_sample(pick_sample(), 1'b0, 16'd0);
    s_tvalid <= 1'b0;

    wait (pending_out.size() == 0);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("tb_crossfaded_waveshaping_distortion OK");
    end else begin
      $display("tb_crossfaded_waveshaping_distortion NOT OK");
    end
    $finish;
  end

endmodule
